FILE: rtl/mzcoff_pkg.sv
// Shared types and constants for the MZ stub and COFF header parser.
`default_nettype none

package mzcoff_pkg;

	localparam logic [15:0] MACHINE_I386  = 16'h014C;
	localparam logic [7:0]  SIG_BYTE0     = 8'h4D;
	localparam logic [7:0]  SIG_BYTE1     = 8'h5A;
	localparam logic [25:0] PAGE_BYTES    = 26'd512;
	localparam logic [25:0] MIN_STUB      = 26'd6;
	localparam logic [31:0] MIN_FILE_LAST = 32'd63;
	localparam logic [15:0] MIN_OPT       = 16'd28;
	localparam logic [16:0] COFF_HDR      = 17'd20;
	localparam logic [5:0]  ENTRY_LAST    = 6'd39;
	localparam int unsigned FIFO_DEPTH    = 4;

	localparam logic KIND_SECTION = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        rec_vld;
		logic        sum_vld;
		logic [15:0] idx;
		logic [63:0] name;
		logic [31:0] vaddr;
		logic [31:0] length;
		logic [31:0] raw_off;
		logic        img_ok;
		logic [31:0] entry;
		logic [31:0] text_base;
		logic [15:0] found;
	} evt_t;

endpackage

`default_nettype wire

FILE: rtl/mzcoff_front.sv
// Front end: byte position tracking, header parsing and section entry capture.
`default_nettype none

module mzcoff_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_file,
	output logic                   push,
	output mzcoff_pkg::evt_t       evt
);
	import mzcoff_pkg::*;

	logic [31:0] pos_q;
	logic        sig_ok_q;
	logic [15:0] last_q;
	logic [15:0] pages_q;
	logic [25:0] coff_q;
	logic        usable_q;
	logic        in_coff_q;
	logic [16:0] r_q;
	logic [15:0] mach_q;
	logic        seen_q;
	logic [15:0] total_q;
	logic [15:0] opt_q;
	logic [31:0] entry_q;
	logic [31:0] text_q;
	logic        in_sec_q;
	logic [5:0]  off_q;
	logic [15:0] idx_q;
	logic [15:0] done_q;
	logic [63:0] name_q;
	logic [31:0] va_q;
	logic [31:0] len_q;
	logic [31:0] raw_q;

	logic        active;
	logic [16:0] r;
	logic [16:0] r_next;
	logic [15:0] pages_new;
	logic [25:0] stub_len;
	logic        usable_new;
	logic [15:0] mach_d;
	logic        seen_d;
	logic [15:0] total_d;
	logic [15:0] opt_d;
	logic [31:0] entry_d;
	logic [31:0] text_d;
	logic [16:0] table_start;
	logic        sec_here;
	logic        sec_live;
	logic        mach_ok;
	logic        rec;
	logic [15:0] done_d;
	logic        img_ok;
	logic        opt_ok;

	always_comb begin
		active = usable_q && (in_coff_q || (pos_q == {6'd0, coff_q}));
		r = in_coff_q ? r_q : '0;
		r_next = (r == '1) ? r : r + 17'd1;

		pages_new = {data_byte, pages_q[7:0]};
		stub_len = {1'b0, pages_new, 9'd0};
		if (last_q != 16'd0) begin
			stub_len = stub_len - PAGE_BYTES + {10'd0, last_q};
		end
		usable_new = sig_ok_q && !(pages_new == 16'd0 && last_q != 16'd0)
			&& (stub_len >= MIN_STUB);

		mach_d = mach_q;
		seen_d = seen_q;
		total_d = total_q;
		opt_d = opt_q;
		entry_d = entry_q;
		text_d = text_q;
		if (active) begin
			case (r)
				17'd0: mach_d[7:0] = data_byte;
				17'd1: begin
					mach_d[15:8] = data_byte;
					seen_d = 1'b1;
				end
				17'd2: total_d[7:0] = data_byte;
				17'd3: total_d[15:8] = data_byte;
				17'd16: opt_d[7:0] = data_byte;
				17'd17: opt_d[15:8] = data_byte;
				default: ;
			endcase
			if (r >= 17'd36 && r < 17'd40) begin
				entry_d[{r[1:0], 3'b000} +: 8] = data_byte;
			end
			if (r >= 17'd40 && r < 17'd44) begin
				text_d[{r[1:0], 3'b000} +: 8] = data_byte;
			end
		end

		table_start = {1'b0, opt_q} + COFF_HDR;
		sec_here = active && (r >= 17'd18) && (in_sec_q || (r == table_start));
		sec_live = sec_here && (idx_q < total_q);
		mach_ok = seen_q && (mach_q == MACHINE_I386);
		rec = sec_live && mach_ok && (off_q == ENTRY_LAST);
		done_d = done_q + {15'd0, rec};

		img_ok = (pos_q >= MIN_FILE_LAST) && usable_q && seen_d && (mach_d == MACHINE_I386);
		opt_ok = img_ok && (opt_d >= MIN_OPT);
	end

	assign push = accept && (rec || end_of_file);

	always_comb begin
		evt.rec_vld = rec;
		evt.sum_vld = end_of_file;
		evt.idx = idx_q;
		evt.name = name_q;
		evt.vaddr = va_q;
		evt.length = len_q;
		evt.raw_off = raw_q;
		evt.img_ok = img_ok;
		evt.entry = opt_ok ? entry_d : 32'd0;
		evt.text_base = opt_ok ? text_d : 32'd0;
		evt.found = img_ok ? done_d : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sig_ok_q <= 1'b0;
			last_q <= '0;
			pages_q <= '0;
			coff_q <= '0;
			usable_q <= 1'b0;
			in_coff_q <= 1'b0;
			r_q <= '0;
			mach_q <= '0;
			seen_q <= 1'b0;
			total_q <= '0;
			opt_q <= '0;
			entry_q <= '0;
			text_q <= '0;
			in_sec_q <= 1'b0;
			off_q <= '0;
			idx_q <= '0;
			done_q <= '0;
		end else if (accept) begin
			if (end_of_file) begin
				pos_q <= '0;
				sig_ok_q <= 1'b0;
				last_q <= '0;
				pages_q <= '0;
				coff_q <= '0;
				usable_q <= 1'b0;
				in_coff_q <= 1'b0;
				r_q <= '0;
				mach_q <= '0;
				seen_q <= 1'b0;
				total_q <= '0;
				opt_q <= '0;
				entry_q <= '0;
				text_q <= '0;
				in_sec_q <= 1'b0;
				off_q <= '0;
				idx_q <= '0;
				done_q <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 32'd1;
				end
				case (pos_q)
					32'd0: sig_ok_q <= (data_byte == SIG_BYTE0);
					32'd1: sig_ok_q <= sig_ok_q && (data_byte == SIG_BYTE1);
					32'd2: last_q[7:0] <= data_byte;
					32'd3: last_q[15:8] <= data_byte;
					32'd4: pages_q[7:0] <= data_byte;
					32'd5: begin
						pages_q <= pages_new;
						coff_q <= stub_len;
						usable_q <= usable_new;
					end
					default: ;
				endcase
				mach_q <= mach_d;
				seen_q <= seen_d;
				total_q <= total_d;
				opt_q <= opt_d;
				entry_q <= entry_d;
				text_q <= text_d;
				if (active) begin
					in_coff_q <= 1'b1;
					r_q <= r_next;
				end
				if (sec_here) begin
					in_sec_q <= 1'b1;
				end
				if (sec_live) begin
					if (off_q == ENTRY_LAST) begin
						off_q <= '0;
						idx_q <= idx_q + 16'd1;
					end else begin
						off_q <= off_q + 6'd1;
					end
				end
				done_q <= done_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sec_live) begin
			if (off_q < 6'd8) begin
				name_q[{off_q[2:0], 3'b000} +: 8] <= data_byte;
			end else if (off_q >= 6'd12 && off_q < 6'd16) begin
				va_q[{off_q[1:0], 3'b000} +: 8] <= data_byte;
			end else if (off_q >= 6'd16 && off_q < 6'd20) begin
				len_q[{off_q[1:0], 3'b000} +: 8] <= data_byte;
			end else if (off_q >= 6'd20 && off_q < 6'd24) begin
				raw_q[{off_q[1:0], 3'b000} +: 8] <= data_byte;
			end
		end
	end

`ifndef SYNTHESIS
	a_sec_after_coff: assert property (@(posedge clk) disable iff (!arst_n)
		in_sec_q |-> in_coff_q && usable_q)
		else $error("section table reached outside the COFF header");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_sec_q |-> idx_q <= total_q)
		else $error("section index ran past the section count");
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= idx_q)
		else $error("more records emitted than table entries walked");
`endif

endmodule

`default_nettype wire

FILE: rtl/mzcoff_fifo.sv
// Small queue of parse events between the front end and the output stage.
`default_nettype none

module mzcoff_fifo #(
	parameter int unsigned Depth = mzcoff_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  mzcoff_pkg::evt_t       wr_data,
	output logic                   full,
	input  wire logic              pop,
	output mzcoff_pkg::evt_t       rd_data,
	output logic                   empty
);
	import mzcoff_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

	evt_t          mem_q [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("event queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("event queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("event queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/mzcoff_back.sv
// Output stage: turns queued events into section records and summaries.
`default_nettype none

module mzcoff_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  mzcoff_pkg::evt_t       head,
	input  wire logic              empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   kind,
	output logic [15:0]            section_index,
	output logic [63:0]            section_name,
	output logic [31:0]            virtual_address,
	output logic [31:0]            section_length,
	output logic [31:0]            raw_data_offset,
	output logic                   image_valid,
	output logic [31:0]            entry_point,
	output logic [31:0]            text_base_address,
	output logic [15:0]            sections_found,
	output logic                   final_result
);
	import mzcoff_pkg::*;

	logic out_valid_q;
	logic rec_sent_q;
	logic load;
	logic send_rec;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign send_rec = head.rec_vld && !rec_sent_q;
	assign pop = load && !(send_rec && head.sum_vld);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_sent_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				rec_sent_q <= send_rec && head.sum_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_rec) begin
				kind <= KIND_SECTION;
				section_index <= head.idx;
				section_name <= head.name;
				virtual_address <= head.vaddr;
				section_length <= head.length;
				raw_data_offset <= head.raw_off;
				image_valid <= 1'b0;
				entry_point <= '0;
				text_base_address <= '0;
				sections_found <= '0;
				final_result <= 1'b0;
			end else begin
				kind <= KIND_SUMMARY;
				section_index <= '0;
				section_name <= '0;
				virtual_address <= '0;
				section_length <= '0;
				raw_data_offset <= '0;
				image_valid <= head.img_ok;
				entry_point <= head.entry;
				text_base_address <= head.text_base;
				sections_found <= head.found;
				final_result <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_split_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rec_sent_q |-> !empty && head.rec_vld && head.sum_vld)
		else $error("summary half pending without a matching queue entry");
	a_no_empty_evt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head.rec_vld || head.sum_vld)
		else $error("queue entry carries no result");
	a_pop_summary: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.sum_vld |=> out_valid_q && final_result)
		else $error("summary entry retired without a summary transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/mz_coff_header_parser.sv
// A result is queued when its byte is accepted and then registered in the output stage.
// Throughput: one byte per cycle while in_stall is low; a byte that closes both a section
// entry and the file yields two results, a section record and then a summary.
// The event queue between front end and output stage absorbs output stalls.
// Reset: arst_n clears all control state at once; there is no clearing pass.
// Top level of the MZ stub and COFF header parser.
`default_nettype none

module mz_coff_header_parser #(
	parameter int unsigned FifoDepth = mzcoff_pkg::FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [15:0]      section_index,
	output logic [63:0]      section_name,
	output logic [31:0]      virtual_address,
	output logic [31:0]      section_length,
	output logic [31:0]      raw_data_offset,
	output logic             image_valid,
	output logic [31:0]      entry_point,
	output logic [31:0]      text_base_address,
	output logic [15:0]      sections_found,
	output logic             final_result
);
	import mzcoff_pkg::*;

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic empty;
	evt_t evt;
	evt_t head;

	assign in_stall = full;
	assign accept = in_valid && !full;

	mzcoff_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.push        (push),
		.evt         (evt)
	);

	mzcoff_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (evt),
		.full    (full),
		.pop     (pop),
		.rd_data (head),
		.empty   (empty)
	);

	mzcoff_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.empty             (empty),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.section_index     (section_index),
		.section_name      (section_name),
		.virtual_address   (virtual_address),
		.section_length    (section_length),
		.raw_data_offset   (raw_data_offset),
		.image_valid       (image_valid),
		.entry_point       (entry_point),
		.text_base_address (text_base_address),
		.sections_found    (sections_found),
		.final_result      (final_result)
	);

endmodule

`default_nettype wire
